>>> rtl/core/dcod_pkg.sv
package dcod_pkg;

  // timing windows
  localparam logic [15:0] EARLY_MS = 16'd1000;
  localparam logic [31:0] CHECK_WAIT_MS = 32'd500;
  localparam logic [16:0] BEMF_DELAY_MS = 17'd3000;

  // position limits, pulses
  localparam logic signed [15:0] FAR_POS = 16'sd4000;
  localparam logic signed [15:0] NEAR_POS = 16'sd5;

  // velocity limits
  localparam logic signed [16:0] VEL_SLOW_FAR = 17'sd1;
  localparam logic signed [16:0] VEL_SLOW_MID = 17'sd2;
  localparam logic signed [16:0] VEL_NORM = 17'sd4;

  // current thresholds
  localparam logic [11:0] SLOW_CUR = 12'd500;
  localparam logic [11:0] SLOW_FAR_CUR = 12'd300;
  localparam logic [11:0] END_CUR_SWITCH = 12'd400;
  localparam logic [11:0] NORM_CUR1 = 12'd300;
  localparam logic [11:0] NORM_CUR23 = 12'd150;
  localparam logic [11:0] BEMF_OBS_CUR = 12'd500;
  localparam logic [11:0] BEMF_END_CUR = 12'd300;

  // hold counts
  localparam logic [7:0] BEMF_HOLD = 8'd3;
  localparam logic [7:0] HOLD23 = 8'd20;
  localparam logic [7:0] HOLD1 = 8'd5;
  localparam logic [7:0] COUNT_MAX = 8'd255;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic [15:0]        elapsed_ms;
    logic signed [15:0] position;
    logic [11:0]        motor_current;
    logic               door_closed_switch;
    logic               lock_switch;
    logic               close_switch;
    logic               slow_mode;
    logic               encoder_fault;
    logic               clear_count;
  } item_t;

  typedef struct packed {
    logic [7:0]         hit_counter;
    logic [7:0]         obstacle_count;
    logic signed [15:0] last_position;
    logic               check_armed;
    logic [31:0]        check_start_ms;
  } state_t;

  typedef struct packed {
    logic       closed_by_position;
    logic       closed_by_current;
    logic       reopen_request;
    logic       stop_regulation;
    logic       force_closed;
    logic [7:0] obstacle_total;
  } result_t;

endpackage

>>> rtl/core/dcod_eval.sv
module dcod_eval
  import dcod_pkg::*;
(
  input  item_t       item,
  input  state_t      st,
  input  logic [15:0] extra_close_ms,
  output state_t      st_next,
  output result_t     res
);

  typedef struct packed {
    logic [7:0]  hc;
    logic [7:0]  oc;
    logic        armed;
    logic [31:0] start;
    logic        f_pos;
    logic        f_cur;
    logic        f_reopen;
    logic        f_stop;
    logic        f_force;
  } work_t;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == COUNT_MAX) ? v : v + 8'd1;
  endfunction

  // velocity-qualified obstacle rules, hold count chosen by obstacle count
  function automatic work_t obstacle_rules(input work_t w_in, input logic [11:0] cur,
                                           input logic [11:0] th1, input logic [7:0] need1,
                                           input logic [11:0] th23);
    work_t w;
    w = w_in;
    if (w.oc == 8'd0) begin
      if (cur > th1) begin
        w.hc = w.hc + 8'd1;
        if (w.hc >= need1) begin
          w.f_stop = 1'b1;
          w.hc = '0;
          w.oc = sat_inc(w.oc);
          w.f_reopen = 1'b1;
        end
      end else begin
        w.hc = '0;
      end
    end else if (cur > th23) begin
      w.hc = w.hc + 8'd1;
      if (w.hc > HOLD23) begin
        w.hc = '0;
        w.oc = sat_inc(w.oc);
        w.f_reopen = 1'b1;
      end
    end
    return w;
  endfunction

  work_t              w;
  logic signed [16:0] vel;
  logic               late;
  logic [11:0]        cur;
  logic               dcl;
  logic               dls;
  logic               dcs;
  logic signed [15:0] pos;
  logic [31:0]        wait_ms;
  logic [16:0]        bemf_limit;

  always_comb begin
    w = '0;
    w.hc = st.hit_counter;
    w.oc = item.clear_count ? 8'd0 : st.obstacle_count;
    w.armed = st.check_armed;
    w.start = st.check_start_ms;
    pos = item.position;
    cur = item.motor_current;
    dcl = item.door_closed_switch;
    dls = item.lock_switch;
    dcs = item.close_switch;
    vel = {st.last_position[15], st.last_position} - {pos[15], pos};
    late = item.elapsed_ms > EARLY_MS;
    wait_ms = item.now_ms - st.check_start_ms;
    bemf_limit = {1'b0, extra_close_ms} + BEMF_DELAY_MS;
    st_next.last_position = st.last_position;

    if (!item.encoder_fault) begin
      if (item.slow_mode) begin
        if (late) begin
          if (dcl) begin
            w.armed = 1'b0;
            w.hc = '0;
            w.f_pos = 1'b1;
          end else if (pos > FAR_POS) begin
            if (dls) begin
              w.hc = '0;
              w.armed = 1'b0;
              w.f_pos = 1'b1;
            end else if (!w.armed) begin
              w.start = item.now_ms;
              w.armed = 1'b1;
            end else if (wait_ms > CHECK_WAIT_MS && vel < VEL_SLOW_FAR) begin
              if (cur > SLOW_FAR_CUR) begin
                w.hc = w.hc + 8'd1;
                if (w.hc >= HOLD23) begin
                  w.f_stop = 1'b1;
                  w.hc = '0;
                  w.oc = sat_inc(w.oc);
                  w.f_reopen = 1'b1;
                  w.armed = 1'b0;
                end
              end else begin
                w.hc = '0;
              end
            end
          end else if (pos < NEAR_POS) begin
            w.armed = 1'b0;
            if (cur > SLOW_CUR) begin
              w.hc = w.hc + 8'd1;
              if (w.hc >= HOLD23) begin
                w.f_cur = 1'b1;
                w.f_pos = 1'b1;
                w.hc = '0;
                w.f_force = 1'b1;
              end
            end
          end else begin
            w.armed = 1'b0;
            if (vel < VEL_SLOW_MID) begin
              w = obstacle_rules(w, cur, SLOW_CUR, HOLD23, SLOW_CUR);
            end
          end
        end else begin
          if (dcl) begin
            w.f_pos = 1'b1;
          end else if (dls) begin
            if (cur > SLOW_FAR_CUR && (w.hc + 8'd1) >= HOLD23) begin
              w.f_cur = 1'b1;
            end
          end else if (pos < NEAR_POS) begin
            if (cur > END_CUR_SWITCH && (w.hc + 8'd1) >= HOLD23) begin
              w.f_cur = 1'b1;
              w.f_force = 1'b1;
            end
          end
          // early window: counter cleared at end of tick
          w.hc = '0;
        end
      end else begin
        if (late && pos < NEAR_POS) begin
          if (dcl) begin
            w.hc = '0;
            w.f_pos = 1'b1;
          end else if ((dcs || dls) && cur > END_CUR_SWITCH) begin
            w.hc = w.hc + 8'd1;
            if (w.hc > HOLD23) begin
              w.hc = '0;
              w.f_cur = 1'b1;
            end
          end else if (cur > NORM_CUR1) begin
            w.hc = w.hc + 8'd1;
            if (w.hc >= HOLD23) begin
              w.f_cur = 1'b1;
              w.f_pos = 1'b1;
              w.hc = '0;
              w.f_force = 1'b1;
            end
          end
        end else if (late) begin
          if (vel < VEL_NORM) begin
            w = obstacle_rules(w, cur, NORM_CUR1, HOLD1, NORM_CUR23);
          end
        end else begin
          if (dcl) begin
            w.f_pos = 1'b1;
          end else if ((dcs || dls) && cur > END_CUR_SWITCH && (w.hc + 8'd1) > HOLD23) begin
            w.f_cur = 1'b1;
          end
          w.hc = '0;
        end
      end
      st_next.last_position = pos;
    end else if (!dcl) begin
      // back-emf obstacle: counted, no reopen
      if (cur > BEMF_OBS_CUR) begin
        w.hc = w.hc + 8'd1;
        if (w.hc > BEMF_HOLD) begin
          w.hc = '0;
          w.oc = sat_inc(w.oc);
        end
      end
    end else if (cur > BEMF_END_CUR && {1'b0, item.elapsed_ms} > bemf_limit) begin
      w.hc = w.hc + 8'd1;
      if (w.hc > BEMF_HOLD) begin
        w.hc = '0;
        w.f_cur = 1'b1;
      end
    end

    if (dcl) begin
      w.f_pos = 1'b1;
    end

    st_next.hit_counter = w.hc;
    st_next.obstacle_count = w.oc;
    st_next.check_armed = w.armed;
    st_next.check_start_ms = w.start;

    res.closed_by_position = w.f_pos;
    res.closed_by_current = w.f_cur;
    res.reopen_request = w.f_reopen;
    res.stop_regulation = w.f_stop;
    res.force_closed = w.f_force;
    res.obstacle_total = w.oc;
  end

endmodule

>>> rtl/core/door_closing_obstacle_detector_core.sv
// door closing obstacle detector, one transaction per 10 ms control tick
//
// input channel (in_valid / in_ready) carries one tick sample: time stamps,
// encoder position, motor current, switches and mode flags. the output
// channel (out_valid / out_ready) returns one decision set per tick, in order.
// cfg_write_en / cfg_write_data load extra_close_ms, the back-emf end delay
// added to 3000 ms; write it only while no transaction is in flight.
//
// an accepted tick goes into the input register, then through the decision
// logic into the result register, which raises out_valid.
// throughput: one tick per cycle while out_ready is high; decision logic is a
// single pass of compares and small counter updates between the two registers.
//
// reset clears the hit counter, obstacle count, last position, check timer
// and extra_close_ms, and empties both registers.
// when out_ready is low and a result waits, the result register holds and the
// input register keeps one more tick; in_ready drops only when both are full.
module door_closing_obstacle_detector_core
  import dcod_pkg::*;
(
  input  logic               clk,
  input  logic               rst,

  input  logic               cfg_write_en,
  input  logic [15:0]        cfg_write_data,

  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        now_ms,
  input  logic [15:0]        elapsed_ms,
  input  logic signed [15:0] position,
  input  logic [11:0]        motor_current,
  input  logic               door_closed_switch,
  input  logic               lock_switch,
  input  logic               close_switch,
  input  logic               slow_mode,
  input  logic               encoder_fault,
  input  logic               clear_count,

  output logic               out_valid,
  input  logic               out_ready,
  output logic               closed_by_position,
  output logic               closed_by_current,
  output logic               reopen_request,
  output logic               stop_regulation,
  output logic               force_closed,
  output logic [7:0]         obstacle_total
);

  logic [15:0] extra_close_ms;
  item_t       item;
  logic        item_valid;
  state_t      st;
  state_t      st_next;
  result_t     res_next;
  result_t     res;
  logic        advance;

  assign advance = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      extra_close_ms <= '0;
    end else if (cfg_write_en) begin
      extra_close_ms <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.now_ms <= now_ms;
      item.elapsed_ms <= elapsed_ms;
      item.position <= position;
      item.motor_current <= motor_current;
      item.door_closed_switch <= door_closed_switch;
      item.lock_switch <= lock_switch;
      item.close_switch <= close_switch;
      item.slow_mode <= slow_mode;
      item.encoder_fault <= encoder_fault;
      item.clear_count <= clear_count;
    end
  end

  dcod_eval u_eval (
    .item           (item),
    .st             (st),
    .extra_close_ms (extra_close_ms),
    .st_next        (st_next),
    .res            (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign closed_by_position = res.closed_by_position;
  assign closed_by_current = res.closed_by_current;
  assign reopen_request = res.reopen_request;
  assign stop_regulation = res.stop_regulation;
  assign force_closed = res.force_closed;
  assign obstacle_total = res.obstacle_total;

`ifndef ASSERT_OFF
  a_stop_implies_reopen: assert property (@(posedge clk) disable iff (rst)
    out_valid && stop_regulation |-> reopen_request)
    else $error("stop_regulation without reopen_request");

  a_force_implies_current: assert property (@(posedge clk) disable iff (rst)
    out_valid && force_closed |-> closed_by_current)
    else $error("force_closed without closed_by_current");

  a_count_no_wrap: assert property (@(posedge clk) disable iff (rst)
    advance && !item.clear_count |-> st_next.obstacle_count >= st.obstacle_count)
    else $error("obstacle count decreased without clear");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> item_valid && out_valid && !out_ready)
    else $error("input stalled while a register is free");
`endif

endmodule
